@@ design/lzx_match_window_decoder_assert.svh @@
// Assertion macros shared by the LZX match/window decoder modules.
`ifndef LZX_MATCH_WINDOW_DECODER_ASSERT_SVH
`define LZX_MATCH_WINDOW_DECODER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LZXMWD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lzxmwd: implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define LZXMWD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lzxmwd: next-cycle check failed");

`endif

@@ design/lzxmwd_pkg.sv @@
// Types, constants and slot table functions of the LZX match/window decoder.
package lzxmwd_pkg;

  localparam int unsigned BASE_W    = 22;
  localparam int unsigned MAX_EXTRA = 17;
  localparam logic [7:0]  FILL_BYTE = 8'hDC;
  localparam int unsigned MIN_LEN   = 2;
  localparam int unsigned LEN_W     = 9;

  typedef enum logic [1:0] {
    OP_LITERAL = 2'd0,
    OP_MATCH   = 2'd1,
    OP_LOAD    = 2'd2
  } op_e;

  // Command from the token decoder to the copy engine, valid for one cycle.
  typedef struct packed {
    logic             go_single;  // one-word result (literal, load, unused, bad slot)
    logic             literal;    // write lit_byte into the window
    logic             bad;        // slot out of range
    logic             go_match;   // start a window copy
    logic [LEN_W-1:0] len;        // match length in bytes
    logic [7:0]       lit_byte;
  } cmd_t;

  // Number of extra offset bits for a position slot.
  function automatic logic [4:0] slot_extra(logic [5:0] s);
    logic [4:0] e;
    e = s[5:1] - 5'd1;
    if (s < 6'd4) begin
      return 5'd0;
    end
    if (e > 5'(MAX_EXTRA)) begin
      return 5'(MAX_EXTRA);
    end
    return e;
  endfunction

  // Base offset of a position slot (sum of the slot sizes below it).
  function automatic logic [BASE_W-1:0] slot_base(logic [5:0] s);
    logic [4:0] sh;
    logic [5:0] hi;
    sh = s[5:1] - 5'd1;
    hi = s - 6'd36;
    if (s < 6'd4) begin
      return BASE_W'(s);
    end
    if (s < 6'd36) begin
      return {20'd0, 1'b1, s[0]} << sh;
    end
    return BASE_W'(262144) + ({16'd0, hi} << MAX_EXTRA);
  endfunction

endpackage

@@ design/lzxmwd_ram.sv @@
// Generic single-write, single-read RAM with registered read data (read-old on collision).
module lzxmwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/lzxmwd_offset.sv @@
// Repeated offset queue (R0-R2) and slot-to-offset decode.
module lzxmwd_offset #(
  parameter int unsigned WINDOW_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic                   match_i,
  input  logic [15:0]            repeat_a_i,
  input  logic [15:0]            repeat_b_i,
  input  logic [15:0]            repeat_c_i,
  input  logic [5:0]             slot_i,
  input  logic                   aligned_i,
  input  logic [16:0]            verbatim_i,
  input  logic [2:0]             abits_i,
  output logic [WINDOW_BITS-1:0] offset_o
);

  localparam int unsigned BW = lzxmwd_pkg::BASE_W;

  logic [WINDOW_BITS-1:0] r0_q, r1_q, r2_q;
  logic [4:0]             extra;
  logic [16:0]            vmask, amask, addend;
  logic [BW-1:0]          fresh;
  logic [WINDOW_BITS-1:0] fresh_off;

  // explicit offset from slot base and extra bits
  always_comb begin
    extra = lzxmwd_pkg::slot_extra(slot_i);
    vmask = 17'((18'd1 << extra) - 18'd1);
    amask = 17'((18'd1 << (extra - 5'd3)) - 18'd1);
    if (aligned_i && extra > 5'd3) begin
      addend = ((verbatim_i & amask) << 3) | {14'd0, abits_i};
    end else if (aligned_i && extra == 5'd3) begin
      addend = {14'd0, abits_i};
    end else if (extra != 5'd0) begin
      addend = verbatim_i & vmask;
    end else begin
      addend = '0;
    end
    fresh     = lzxmwd_pkg::slot_base(slot_i) - BW'(2) + BW'(addend);
    fresh_off = WINDOW_BITS'(fresh);
  end

  // offset used by this token
  always_comb begin
    case (slot_i)
      6'd0:    offset_o = r0_q;
      6'd1:    offset_o = r1_q;
      6'd2:    offset_o = r2_q;
      default: offset_o = fresh_off;
    endcase
  end

  // most-recently-used queue update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_q <= WINDOW_BITS'(1);
      r1_q <= WINDOW_BITS'(1);
      r2_q <= WINDOW_BITS'(1);
    end else if (load_i) begin
      r0_q <= WINDOW_BITS'(repeat_a_i);
      r1_q <= WINDOW_BITS'(repeat_b_i);
      r2_q <= WINDOW_BITS'(repeat_c_i);
    end else if (match_i) begin
      case (slot_i)
        6'd0: begin
        end
        6'd1: begin
          r0_q <= r1_q;
          r1_q <= r0_q;
        end
        6'd2: begin
          r0_q <= r2_q;
          r2_q <= r0_q;
        end
        default: begin
          r0_q <= fresh_off;
          r1_q <= r0_q;
          r2_q <= r1_q;
        end
      endcase
    end
  end

endmodule

@@ design/lzxmwd_copy.sv @@
// Window copy engine: window RAM, write pointer, byte packing and output register.
`include "lzx_match_window_decoder_assert.svh"

module lzxmwd_copy #(
  parameter int unsigned WINDOW_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lzxmwd_pkg::cmd_t       cmd_i,
  input  logic [WINDOW_BITS-1:0] offset_i,
  output logic                   busy_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [63:0]            out_bytes_o,
  output logic [3:0]             byte_count_o,
  output logic                   last_o,
  output logic                   bad_slot_o
);

  localparam int unsigned WB    = WINDOW_BITS;
  localparam int unsigned LW    = lzxmwd_pkg::LEN_W;
  localparam logic [7:0]  FILLB = lzxmwd_pkg::FILL_BYTE;

  // copy control
  logic          busy_q, hold_q;
  logic [LW-1:0] rem_q;
  logic [2:0]    wcnt_q;
  logic [WB-1:0] off_q, pos_q;
  logic          wrap_q;

  // write stage (read data arrives)
  logic          w_valid_q, w_unwr_q, w_fwd_q, w_wend_q, w_last_q;
  logic [WB-1:0] w_dst_q;
  logic [7:0]    w_fwd_byte_q;

  // word assembly
  logic [63:0]   acc_q, acc_d;
  logic [3:0]    fill_q;
  logic          ready_q, rlast_q;

  // output register
  logic          ov_q, olast_q, obad_q;
  logic [63:0]   obytes_q;
  logic [3:0]    ocount_q;

  logic          issue, out_free, transfer, we, word_end;
  logic [WB-1:0] rd_addr, wa;
  logic [7:0]    wd, rd_data, w_byte;

  assign issue    = busy_q && (rem_q != '0) && !hold_q;
  assign rd_addr  = pos_q - off_q;
  assign out_free = !ov_q || !out_stall_i;
  assign transfer = ready_q && out_free;
  assign word_end = (wcnt_q == 3'd7) || (rem_q == LW'(1));

  // byte landing this cycle: forwarded, never written, or from the RAM
  assign w_byte = w_fwd_q ? w_fwd_byte_q : (w_unwr_q ? FILLB : rd_data);

  // single write port: copy write-back or literal
  assign we = w_valid_q || cmd_i.literal;
  assign wa = w_valid_q ? w_dst_q : pos_q;
  assign wd = w_valid_q ? w_byte : cmd_i.lit_byte;

  lzxmwd_ram #(
    .WIDTH (8),
    .DEPTH (1 << WINDOW_BITS)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wa),
    .wdata_i (wd),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // pack the landing byte into the current word
  always_comb begin
    acc_d = acc_q;
    acc_d[{fill_q[2:0], 3'b000} +: 8] = w_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      hold_q    <= 1'b0;
      rem_q     <= '0;
      wcnt_q    <= '0;
      off_q     <= '0;
      pos_q     <= '0;
      wrap_q    <= 1'b0;
      w_valid_q <= 1'b0;
      w_wend_q  <= 1'b0;
      w_last_q  <= 1'b0;
      acc_q     <= '0;
      fill_q    <= '0;
      ready_q   <= 1'b0;
      rlast_q   <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      // start of a match
      if (cmd_i.go_match) begin
        busy_q <= 1'b1;
        hold_q <= 1'b0;
        rem_q  <= cmd_i.len;
        wcnt_q <= '0;
        off_q  <= offset_i;
      end

      // write pointer advances on each issued copy byte and each literal
      if (issue || cmd_i.literal) begin
        pos_q <= pos_q + WB'(1);
        if (pos_q == '1) begin
          wrap_q <= 1'b1;
        end
      end

      // issue one read per cycle, at most one word at a time
      w_valid_q <= issue;
      if (issue) begin
        rem_q     <= rem_q - LW'(1);
        wcnt_q    <= wcnt_q + 3'd1;
        w_wend_q  <= word_end;
        w_last_q  <= (rem_q == LW'(1));
        if (word_end) begin
          hold_q <= 1'b1;
        end
      end

      // landing byte joins the word
      if (w_valid_q) begin
        acc_q  <= acc_d;
        fill_q <= fill_q + 4'd1;
        if (w_wend_q) begin
          ready_q <= 1'b1;
          rlast_q <= w_last_q;
        end
      end

      // output register
      if (cmd_i.go_single) begin
        ov_q <= 1'b1;
      end else if (transfer) begin
        ov_q    <= 1'b1;
        acc_q   <= '0;
        fill_q  <= '0;
        ready_q <= 1'b0;
        hold_q  <= 1'b0;
        wcnt_q  <= '0;
        if (rlast_q) begin
          busy_q <= 1'b0;
        end
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // write-stage payload and output payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      w_dst_q      <= pos_q;
      w_unwr_q     <= !(wrap_q || (rd_addr < pos_q));
      w_fwd_q      <= we && (wa == rd_addr);
      w_fwd_byte_q <= wd;
    end
    if (cmd_i.go_single) begin
      obytes_q <= cmd_i.literal ? {56'd0, cmd_i.lit_byte} : 64'd0;
      ocount_q <= cmd_i.literal ? 4'd1 : 4'd0;
      olast_q  <= 1'b1;
      obad_q   <= cmd_i.bad;
    end else if (transfer) begin
      obytes_q <= acc_q;
      ocount_q <= fill_q;
      olast_q  <= rlast_q;
      obad_q   <= 1'b0;
    end
  end

  assign busy_o       = busy_q;
  assign out_valid_o  = ov_q;
  assign out_bytes_o  = obytes_q;
  assign byte_count_o = ocount_q;
  assign last_o       = olast_q;
  assign bad_slot_o   = obad_q;

  // an empty word is always the only word of its token
  `LZXMWD_ASSERT_IMP(a_empty_is_last, clk_i, rst_ni, ov_q && (ocount_q == 4'd0), olast_q)
  // every word but the last of a match is full
  `LZXMWD_ASSERT_IMP(a_inner_full, clk_i, rst_ni, ov_q && !olast_q, ocount_q == 4'd8)
  // a bad slot flag comes with an empty final word
  `LZXMWD_ASSERT_IMP(a_bad_empty, clk_i, rst_ni, ov_q && obad_q,
                     (ocount_q == 4'd0) && olast_q)
  // a completed word stops further reads until it leaves
  `LZXMWD_ASSERT_NXT(a_word_holds, clk_i, rst_ni, w_valid_q && w_wend_q, !w_valid_q)

endmodule

@@ design/lzx_match_window_decoder.sv @@
// Top level of the LZX match/window decoder: token decode, handshake and unit wiring.
//
// Input channel (in_valid_i / in_stall_o) carries one decoded LZX token per word:
// a literal byte, a match (slot, length header/footer, verbatim and aligned bits),
// or a load of the three repeated offsets. Output channel (out_valid_o /
// out_stall_i) returns the produced bytes, up to eight per word, with last_o on
// the final word of each token and bad_slot_o when the slot exceeds the window.
// A single-word token's result word is registered in the cycle after acceptance;
// a match passes through the copy control, the write stage, word assembly and
// the output register. Literal, load, unused and bad-slot tokens are accepted
// one per cycle while the output is drained. For a match, the window RAM has one
// read port, so bytes are copied one per cycle, pausing after each word of eight
// until that word has been handed over to the output register.
// The window is a 2^WINDOW_BITS byte RAM; bytes not yet written since reset read
// as 0xDC, tracked by the write pointer and a wrap flag, so no clearing pass runs.
// Reset (rst_ni low, asynchronous) empties the pipeline, zeroes the write pointer
// and sets R0-R2 to one. When the receiver stalls, the output word holds and no
// further token is taken until the word has been accepted.
module lzx_match_window_decoder #(
  parameter int unsigned WINDOW_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  byte_value_i,
  input  logic        aligned_block_i,
  input  logic [5:0]  position_slot_i,
  input  logic [2:0]  length_header_i,
  input  logic [7:0]  length_footer_i,
  input  logic [16:0] verbatim_bits_i,
  input  logic [2:0]  aligned_bits_i,
  input  logic [15:0] repeat_a_i,
  input  logic [15:0] repeat_b_i,
  input  logic [15:0] repeat_c_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_bytes_o,
  output logic [3:0]  byte_count_o,
  output logic        last_o,
  output logic        bad_slot_o
);

  localparam int unsigned SLOT_LIMIT = (WINDOW_BITS == 20) ? 42 :
                                       (WINDOW_BITS == 21) ? 50 : 2 * WINDOW_BITS;
  localparam int unsigned LW = lzxmwd_pkg::LEN_W;

  logic                   busy, accept, slot_bad, is_load, is_match;
  logic [LW-1:0]          len;
  logic [WINDOW_BITS-1:0] offset;
  lzxmwd_pkg::cmd_t       cmd;

  assign in_stall_o = busy || (out_valid_o && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_bad   = (position_slot_i >= 6'(SLOT_LIMIT));

  // match length: header plus two, footer added when header is all ones
  assign len = (length_header_i == 3'd7)
             ? LW'(7 + lzxmwd_pkg::MIN_LEN) + LW'(length_footer_i)
             : LW'(length_header_i) + LW'(lzxmwd_pkg::MIN_LEN);

  // token decode into a one-cycle command
  always_comb begin
    cmd          = '0;
    cmd.len      = len;
    cmd.lit_byte = byte_value_i;
    is_load      = 1'b0;
    is_match     = 1'b0;
    case (lzxmwd_pkg::op_e'(op_i))
      lzxmwd_pkg::OP_LITERAL: begin
        cmd.literal = accept;
      end
      lzxmwd_pkg::OP_MATCH: begin
        is_match = !slot_bad;
        cmd.bad  = slot_bad;
      end
      lzxmwd_pkg::OP_LOAD: begin
        is_load = 1'b1;
      end
      default: begin
      end
    endcase
    cmd.go_match  = accept && is_match;
    cmd.go_single = accept && !is_match;
  end

  lzxmwd_offset #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_offset (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept && is_load),
    .match_i    (cmd.go_match),
    .repeat_a_i (repeat_a_i),
    .repeat_b_i (repeat_b_i),
    .repeat_c_i (repeat_c_i),
    .slot_i     (position_slot_i),
    .aligned_i  (aligned_block_i),
    .verbatim_i (verbatim_bits_i),
    .abits_i    (aligned_bits_i),
    .offset_o   (offset)
  );

  lzxmwd_copy #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_copy (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .offset_i     (offset),
    .busy_o       (busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_bytes_o  (out_bytes_o),
    .byte_count_o (byte_count_o),
    .last_o       (last_o),
    .bad_slot_o   (bad_slot_o)
  );

endmodule
